// ----- rtl/scpr_pkg.sv -----
// scpr_pkg: shared constants for the serial command pattern receiver
// no dependencies; used by serial_command_pattern_receiver

package scpr_pkg;

    // beat operation codes on the mode field
    localparam logic [1:0] MODE_RECEIVE     = 2'd0;
    localparam logic [1:0] MODE_CLEAR       = 2'd1;
    localparam logic [1:0] MODE_CLEAR_FLAGS = 2'd2;
    localparam logic [1:0] MODE_READ        = 2'd3;

    // receive phase codes
    localparam logic [1:0] PHASE_START_DETECT = 2'd0;
    localparam logic [1:0] PHASE_IMAGE_COUNT  = 2'd1;
    localparam logic [1:0] PHASE_RESET_DETECT = 2'd2;
    localparam logic [1:0] PHASE_STORE_ONLY   = 2'd3;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_RECEIVE_PHASE      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_START_CODE         = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RESET_CODE         = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ZERO_RUN_THRESHOLD = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_END_LIMIT    = 3'd4;

    localparam int unsigned CFG_DATA_W = 64;

    // command framing bytes
    localparam logic [7:0] CMD_OPEN  = 8'hEF;
    localparam logic [7:0] CMD_CLOSE = 8'hFF;
    localparam logic [7:0] ZERO_BYTE = 8'h00;

    // register reset values
    localparam logic [63:0] START_CODE_RESET = 64'h0807_0605_0403_0201;
    localparam logic [63:0] RESET_CODE_RESET = 64'hF8F7_F6F5_F4F3_F2F5;
    localparam logic [7:0]  ZERO_RUN_THRESHOLD_RESET = 8'd50;
    localparam logic [23:0] IMAGE_END_LIMIT_RESET    = 24'd0;

    // code position holds 0..8, the longest command
    localparam int unsigned POS_W = 4;

endpackage

// ----- rtl/scpr_ram.sv -----
// scpr_ram: generic simple dual port ram, one write and one registered read port
// no dependencies

module scpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/serial_command_pattern_receiver.sv -----
// serial_command_pattern_receiver: ring buffer, command matcher and image counter
// depends on scpr_pkg and scpr_ram

// The block takes one input beat per clock and returns one result beat per input beat,
// in order. A mode 0 beat stores its byte at the next ring buffer slot and feeds the
// start or reset command matcher or the image counter, as the receive phase selects,
// none in store-only phase; mode 1 clears the buffer and the received and image counts,
// mode 2 the command flags, mode 3 reads one buffer entry. The buffer ram has a write
// port and a registered read port, so a write and a read never contend and a read just
// after a write to the same entry sees the new byte. A clear is instant: entries at or
// past the write position read as zero until the buffer wraps. A stage after the ram
// and an output register let the block take a new beat in every cycle while results
// are taken; while a result waits, one more beat is held, then in_ready drops until it
// is taken. Configuration must be written only while idle; the block does not check.

module serial_command_pattern_receiver #(
    parameter int BUFFER_DEPTH = 256,
    parameter int CODE_LENGTH  = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [scpr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [scpr_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          mode,
    input  logic [7:0]                          rx_byte,
    input  logic [7:0]                          read_index,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [7:0]                          read_data,
    output logic [7:0]                          write_index,
    output logic                                buffer_full,
    output logic                                start_seen,
    output logic                                reset_seen,
    output logic [15:0]                         received_count,
    output logic [23:0]                         image_count,
    output logic [7:0]                          zero_run,
    output logic                                end_detected
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam logic [AW-1:0] WP_LAST = AW'(BUFFER_DEPTH - 1);
    localparam logic [scpr_pkg::POS_W-1:0] POS_LAST = scpr_pkg::POS_W'(CODE_LENGTH);

    typedef enum logic [1:0] {
        M_IDLE,
        M_CODE,
        M_CLOSE
    } match_state_t;

    // snapshot of the state after one beat
    typedef struct packed {
        logic [7:0]  write_index;
        logic        buffer_full;
        logic        start_seen;
        logic        reset_seen;
        logic [15:0] received_count;
        logic [23:0] image_count;
        logic [7:0]  zero_run;
    } status_t;

    // configuration registers
    logic [1:0]  receive_phase_reg;
    logic [63:0] start_code_reg;
    logic [63:0] reset_code_reg;
    logic [7:0]  zero_run_threshold_reg;
    logic [23:0] image_end_limit_reg;

    // block state
    match_state_t               matcher_state_reg, matcher_state_next;
    logic [scpr_pkg::POS_W-1:0] code_pos_reg, code_pos_next;
    logic [AW-1:0]              write_pos_reg, write_pos_next;
    logic                       full_reg, full_next;
    logic                       start_mark_reg, start_mark_next;
    logic                       reset_mark_reg, reset_mark_next;
    logic [15:0]                byte_count_reg, byte_count_next;
    logic [23:0]                image_len_reg, image_len_next;
    logic [7:0]                 zero_run_reg, zero_run_next;

    // pipeline stages
    logic    s1_valid_reg;
    logic    s1_read_reg;
    status_t s1_status_reg;
    logic    out_valid_reg;
    logic    out_read_reg;
    status_t out_status_reg;
    logic [7:0] out_read_data_reg;
    logic       out_end_reg;

    logic        accept;
    logic        s1_move;
    logic        receive_beat;
    logic        run_matcher;
    logic        mark_hit;
    logic [63:0] code_sel;
    logic [7:0]  code_byte;
    logic [15:0] ridx_wide;
    logic [AW-1:0] ridx;
    logic        entry_valid;
    logic        read_beat;
    logic [7:0]  ram_q;
    status_t     status_next;

    // handshake
    assign s1_move  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_move;
    assign accept   = in_valid && in_ready;

    assign receive_beat = accept && (mode == scpr_pkg::MODE_RECEIVE);
    assign run_matcher  = receive_beat &&
                          ((receive_phase_reg == scpr_pkg::PHASE_START_DETECT) ||
                           (receive_phase_reg == scpr_pkg::PHASE_RESET_DETECT));

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            receive_phase_reg      <= scpr_pkg::PHASE_START_DETECT;
            start_code_reg         <= scpr_pkg::START_CODE_RESET;
            reset_code_reg         <= scpr_pkg::RESET_CODE_RESET;
            zero_run_threshold_reg <= scpr_pkg::ZERO_RUN_THRESHOLD_RESET;
            image_end_limit_reg    <= scpr_pkg::IMAGE_END_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                scpr_pkg::REG_RECEIVE_PHASE:      receive_phase_reg <= cfg_data[1:0];
                scpr_pkg::REG_START_CODE:         start_code_reg <= cfg_data;
                scpr_pkg::REG_RESET_CODE:         reset_code_reg <= cfg_data;
                scpr_pkg::REG_ZERO_RUN_THRESHOLD: zero_run_threshold_reg <= cfg_data[7:0];
                scpr_pkg::REG_IMAGE_END_LIMIT:    image_end_limit_reg <= cfg_data[23:0];
                default:                          ;
            endcase
        end
    end

    // expected code byte for the current position
    assign code_sel  = (receive_phase_reg == scpr_pkg::PHASE_START_DETECT) ?
                       start_code_reg : reset_code_reg;
    assign code_byte = code_sel[8*code_pos_reg[2:0] +: 8];

    // command matcher
    always_comb
    begin
        matcher_state_next = matcher_state_reg;
        code_pos_next      = code_pos_reg;
        mark_hit           = 1'b0;
        if (run_matcher)
        begin
            unique case (matcher_state_reg)
                M_IDLE:
                begin
                    if (rx_byte == scpr_pkg::CMD_OPEN)
                    begin
                        matcher_state_next = M_CODE;
                        code_pos_next      = '0;
                    end
                end
                M_CODE:
                begin
                    if (code_pos_reg >= POS_LAST)
                    begin
                        // the byte after the last code byte is skipped
                        matcher_state_next = M_CLOSE;
                    end
                    else if (rx_byte == code_byte)
                    begin
                        code_pos_next = code_pos_reg + 1'b1;
                    end
                    else
                    begin
                        code_pos_next      = '0;
                        matcher_state_next = M_IDLE;
                    end
                end
                M_CLOSE:
                begin
                    if (rx_byte == scpr_pkg::CMD_CLOSE)
                    begin
                        mark_hit           = 1'b1;
                        matcher_state_next = M_IDLE;
                    end
                end
                default:
                begin
                    matcher_state_next = M_IDLE;
                end
            endcase
        end
    end

    // buffer position, counters and flags
    always_comb
    begin
        write_pos_next  = write_pos_reg;
        full_next       = full_reg;
        start_mark_next = start_mark_reg;
        reset_mark_next = reset_mark_reg;
        byte_count_next = byte_count_reg;
        image_len_next  = image_len_reg;
        zero_run_next   = zero_run_reg;
        if (accept)
        begin
            unique case (mode)
                scpr_pkg::MODE_RECEIVE:
                begin
                    if (mark_hit && (receive_phase_reg == scpr_pkg::PHASE_START_DETECT))
                    begin
                        start_mark_next = 1'b1;
                    end
                    if (mark_hit && (receive_phase_reg == scpr_pkg::PHASE_RESET_DETECT))
                    begin
                        reset_mark_next = 1'b1;
                    end
                    if (receive_phase_reg == scpr_pkg::PHASE_IMAGE_COUNT)
                    begin
                        if (image_len_reg != '1)
                        begin
                            image_len_next = image_len_reg + 1'b1;
                        end
                        if (rx_byte == scpr_pkg::ZERO_BYTE)
                        begin
                            if (zero_run_reg != '1)
                            begin
                                zero_run_next = zero_run_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            zero_run_next = '0;
                        end
                    end
                    if (byte_count_reg != '1)
                    begin
                        byte_count_next = byte_count_reg + 1'b1;
                    end
                    if (write_pos_reg == WP_LAST)
                    begin
                        write_pos_next = '0;
                        full_next      = 1'b1;
                    end
                    else
                    begin
                        write_pos_next = write_pos_reg + 1'b1;
                    end
                end
                scpr_pkg::MODE_CLEAR:
                begin
                    write_pos_next  = '0;
                    full_next       = 1'b0;
                    byte_count_next = '0;
                    image_len_next  = '0;
                end
                scpr_pkg::MODE_CLEAR_FLAGS:
                begin
                    start_mark_next = 1'b0;
                    reset_mark_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // read index folded into the buffer depth by conditional subtraction
    always_comb
    begin
        ridx_wide = {8'b0, read_index};
        for (int k = 3; k >= 0; k--)
        begin
            if (ridx_wide >= (16'(BUFFER_DEPTH) << k))
            begin
                ridx_wide = ridx_wide - (16'(BUFFER_DEPTH) << k);
            end
        end
    end
    assign ridx = AW'(ridx_wide);

    // entries past the write position read as zero until the buffer wraps
    assign entry_valid = full_reg || (ridx < write_pos_reg);
    assign read_beat   = accept && (mode == scpr_pkg::MODE_READ);

    scpr_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_buffer (
        .clk   (clk),
        .we    (receive_beat),
        .waddr (write_pos_reg),
        .wdata (rx_byte),
        .re    (read_beat),
        .raddr (ridx),
        .rdata (ram_q)
    );

    // status seen by this beat's result
    always_comb
    begin
        status_next.write_index    = 8'(write_pos_next);
        status_next.buffer_full    = full_next;
        status_next.start_seen     = start_mark_next;
        status_next.reset_seen     = reset_mark_next;
        status_next.received_count = byte_count_next;
        status_next.image_count    = image_len_next;
        status_next.zero_run       = zero_run_next;
    end

    // state registers and control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matcher_state_reg <= M_IDLE;
            code_pos_reg      <= '0;
            write_pos_reg     <= '0;
            full_reg          <= 1'b0;
            start_mark_reg    <= 1'b0;
            reset_mark_reg    <= 1'b0;
            byte_count_reg    <= '0;
            image_len_reg     <= '0;
            zero_run_reg      <= '0;
            s1_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            matcher_state_reg <= matcher_state_next;
            code_pos_reg      <= code_pos_next;
            write_pos_reg     <= write_pos_next;
            full_reg          <= full_next;
            start_mark_reg    <= start_mark_next;
            reset_mark_reg    <= reset_mark_next;
            byte_count_reg    <= byte_count_next;
            image_len_reg     <= image_len_next;
            zero_run_reg      <= zero_run_next;
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload of the two stages
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_status_reg <= status_next;
            s1_read_reg   <= read_beat && entry_valid;
        end
        if (s1_move)
        begin
            out_status_reg    <= s1_status_reg;
            out_read_reg      <= s1_read_reg;
            out_read_data_reg <= s1_read_reg ? ram_q : 8'd0;
            out_end_reg       <= (s1_status_reg.zero_run > zero_run_threshold_reg) &&
                                 (s1_status_reg.image_count > image_end_limit_reg);
        end
    end

    // outputs
    assign out_valid      = out_valid_reg;
    assign read_data      = out_read_data_reg;
    assign write_index    = out_status_reg.write_index;
    assign buffer_full    = out_status_reg.buffer_full;
    assign start_seen     = out_status_reg.start_seen;
    assign reset_seen     = out_status_reg.reset_seen;
    assign received_count = out_status_reg.received_count;
    assign image_count    = out_status_reg.image_count;
    assign zero_run       = out_status_reg.zero_run;
    assign end_detected   = out_end_reg;

`ifndef SYNTHESIS
    // write position stays inside the buffer
    a_write_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        write_pos_reg <= WP_LAST)
        else $error("write position past buffer end");

    // code position never passes the command length
    a_code_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        code_pos_reg <= POS_LAST)
        else $error("code position past command length");

    // a write into the last slot marks the buffer as wrapped
    a_wrap_sets_full: assert property (@(posedge clk) disable iff (!rst_n)
        (receive_beat && (write_pos_reg == WP_LAST)) |=> (full_reg && (write_pos_reg == '0)))
        else $error("wrap did not set full mark");

    // read data is nonzero only on a read beat
    a_read_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (read_data != 8'd0)) |-> out_read_reg)
        else $error("read data on a non-read beat");

    // end of image needs a nonzero zero run
    a_end_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && end_detected) |-> (zero_run != 8'd0))
        else $error("end flagged without zero run");
`endif

endmodule

// ----- sim/serial_command_pattern_receiver_test.sv -----
// serial_command_pattern_receiver_test: self-checking bench for the serial command receiver
// depends on scpr_pkg and serial_command_pattern_receiver with its ram underneath

`timescale 1ns / 100ps

module serial_command_pattern_receiver_test;

    localparam int CODE_LEN = 8;

    // one input beat and one result beat
    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] rx_byte;
        logic [7:0] read_index;
    } beat_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [7:0]  write_index;
        logic        buffer_full;
        logic        start_seen;
        logic        reset_seen;
        logic [15:0] received_count;
        logic [23:0] image_count;
        logic [7:0]  zero_run;
        logic        end_detected;
    } result_t;

    typedef enum logic [1:0] {MATCH_IDLE, MATCH_CODE, MATCH_CLOSE} match_state_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             cfg_we = 1'b0;
    logic [scpr_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [scpr_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
    logic                             in_valid = 1'b0;
    logic                             in_ready;
    logic [1:0]                       mode = scpr_pkg::MODE_RECEIVE;
    logic [7:0]                       rx_byte = '0;
    logic [7:0]                       read_index = '0;
    logic                             out_valid;
    logic                             out_ready = 1'b0;
    logic [7:0]                       read_data;
    logic [7:0]                       write_index;
    logic                             buffer_full;
    logic                             start_seen;
    logic                             reset_seen;
    logic [15:0]                      received_count;
    logic [23:0]                      image_count;
    logic [7:0]                       zero_run;
    logic                             end_detected;

    serial_command_pattern_receiver i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .rx_byte        (rx_byte),
        .read_index     (read_index),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .read_data      (read_data),
        .write_index    (write_index),
        .buffer_full    (buffer_full),
        .start_seen     (start_seen),
        .reset_seen     (reset_seen),
        .received_count (received_count),
        .image_count    (image_count),
        .zero_run       (zero_run),
        .end_detected   (end_detected)
    );

    always #5 clk = ~clk;

    // beats waiting to go out and results waiting to come back
    beat_t   pending_beats[$];
    result_t expected_results[$];

    // register copies
    logic [1:0]  cfg_phase = scpr_pkg::PHASE_START_DETECT;
    logic [63:0] cfg_start_code = scpr_pkg::START_CODE_RESET;
    logic [63:0] cfg_reset_code = scpr_pkg::RESET_CODE_RESET;
    logic [7:0]  cfg_zero_threshold = scpr_pkg::ZERO_RUN_THRESHOLD_RESET;
    logic [23:0] cfg_image_limit = scpr_pkg::IMAGE_END_LIMIT_RESET;

    // receiver state copies
    match_state_t match_state = MATCH_IDLE;
    logic [3:0]   code_pos = '0;
    logic [7:0]   ring [256];
    logic [7:0]   wr_pos = '0;
    logic         full_mark = 1'b0;
    logic         start_mark = 1'b0;
    logic         reset_mark = 1'b0;
    logic [15:0]  byte_cnt = '0;
    logic [23:0]  image_len = '0;
    logic [7:0]   zero_len = '0;

    // bench control and tallies
    bit          no_idle = 1'b0;
    bit          sender_hold = 1'b0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    beat_t       cur_beat = '0;
    int          beats_sent = 0;
    int          results_checked = 0;
    int          commands_found = 0;
    int          end_flags = 0;
    int          cfg_writes = 0;
    int          mismatches = 0;
    int          reports = 0;

    initial
    begin
        foreach (ring[i]) ring[i] = '0;
    end

    // random gap: mostly none, some short, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 20);
        return $urandom_range(30, 100);
    endfunction

    // random byte
    function automatic logic [7:0] rnd8(int unsigned lo, int unsigned hi);
        return 8'($urandom_range(lo, hi));
    endfunction

    // command matcher, returns 1 when a full command closes
    function automatic bit match_step(logic [7:0] d, logic [63:0] code);
        bit done;
        done = 1'b0;
        unique case (match_state)
            MATCH_IDLE:
                if (d == scpr_pkg::CMD_OPEN)
                begin
                    match_state = MATCH_CODE;
                    code_pos = '0;
                end
            MATCH_CODE:
                if (code_pos >= CODE_LEN)
                begin
                    // byte after the last code byte is skipped
                    match_state = MATCH_CLOSE;
                end
                else if (d == code[8*code_pos +: 8])
                begin
                    code_pos = code_pos + 1'b1;
                end
                else
                begin
                    code_pos = '0;
                    match_state = MATCH_IDLE;
                end
            MATCH_CLOSE:
                if (d == scpr_pkg::CMD_CLOSE)
                begin
                    done = 1'b1;
                    match_state = MATCH_IDLE;
                end
            default:
                match_state = MATCH_IDLE;
        endcase
        return done;
    endfunction

    // advance the state copy by one beat and return the result it shows
    function automatic result_t predict_beat(beat_t b);
        result_t r;
        logic [7:0] rd;
        rd = '0;
        unique case (b.mode)
            scpr_pkg::MODE_RECEIVE:
            begin
                unique case (cfg_phase)
                    scpr_pkg::PHASE_START_DETECT:
                        if (match_step(b.rx_byte, cfg_start_code))
                        begin
                            start_mark = 1'b1;
                            commands_found++;
                        end
                    scpr_pkg::PHASE_IMAGE_COUNT:
                    begin
                        if (image_len != 24'hFF_FFFF) image_len = image_len + 1'b1;
                        if (b.rx_byte == scpr_pkg::ZERO_BYTE)
                        begin
                            if (zero_len != 8'hFF) zero_len = zero_len + 1'b1;
                        end
                        else
                        begin
                            zero_len = '0;
                        end
                    end
                    scpr_pkg::PHASE_RESET_DETECT:
                        if (match_step(b.rx_byte, cfg_reset_code))
                        begin
                            reset_mark = 1'b1;
                            commands_found++;
                        end
                    default: ;
                endcase
                ring[wr_pos] = b.rx_byte;
                wr_pos = wr_pos + 1'b1;
                if (wr_pos == 8'd0) full_mark = 1'b1;
                if (byte_cnt != 16'hFFFF) byte_cnt = byte_cnt + 1'b1;
            end
            scpr_pkg::MODE_CLEAR:
            begin
                wr_pos = '0;
                byte_cnt = '0;
                image_len = '0;
                full_mark = 1'b0;
                foreach (ring[i]) ring[i] = '0;
            end
            scpr_pkg::MODE_CLEAR_FLAGS:
            begin
                start_mark = 1'b0;
                reset_mark = 1'b0;
            end
            default:
                rd = ring[b.read_index];
        endcase
        r.read_data      = rd;
        r.write_index    = wr_pos;
        r.buffer_full    = full_mark;
        r.start_seen     = start_mark;
        r.reset_seen     = reset_mark;
        r.received_count = byte_cnt;
        r.image_count    = image_len;
        r.zero_run       = zero_len;
        r.end_detected   = (zero_len > cfg_zero_threshold) && (image_len > cfg_image_limit);
        return r;
    endfunction

    function automatic string show_result(result_t r);
        return $sformatf("rd=%h wi=%h full=%b st=%b rs=%b cnt=%h img=%h zr=%h end=%b",
                         r.read_data, r.write_index, r.buffer_full, r.start_seen,
                         r.reset_seen, r.received_count, r.image_count, r.zero_run,
                         r.end_detected);
    endfunction

    // driver: present pending beats with random gaps, predict each accepted one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            mode       <= scpr_pkg::MODE_RECEIVE;
            rx_byte    <= '0;
            read_index <= '0;
            gap_left   = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_results.push_back(predict_beat(cur_beat));
                beats_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_beats.size() != 0 && !sender_hold)
                begin
                    cur_beat   = pending_beats.pop_front();
                    mode       <= cur_beat.mode;
                    rx_byte    <= cur_beat.rx_byte;
                    read_index <= cur_beat.read_index;
                    in_valid   <= 1'b1;
                    gap_left   = pick_gap();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: random stalls, check each result beat against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                result_t seen;
                result_t want;
                seen.read_data      = read_data;
                seen.write_index    = write_index;
                seen.buffer_full    = buffer_full;
                seen.start_seen     = start_seen;
                seen.reset_seen     = reset_seen;
                seen.received_count = received_count;
                seen.image_count    = image_count;
                seen.zero_run       = zero_run;
                seen.end_detected   = end_detected;
                if (seen.end_detected === 1'b1) end_flags++;
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (reports < 10)
                    begin
                        reports++;
                        $display("unexpected result beat: %s", show_result(seen));
                    end
                end
                else
                begin
                    want = expected_results.pop_front();
                    results_checked++;
                    if (seen !== want)
                    begin
                        mismatches++;
                        if (reports < 10)
                        begin
                            reports++;
                            $display("result %0d mismatch", results_checked);
                            $display("  expected %s", show_result(want));
                            $display("  actual   %s", show_result(seen));
                        end
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready  <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // stimulus helpers
    task automatic add_beat(logic [1:0] m, logic [7:0] d, logic [7:0] idx);
        beat_t t;
        t.mode       = m;
        t.rx_byte    = d;
        t.read_index = idx;
        pending_beats.push_back(t);
    endtask

    task automatic add_rx(logic [7:0] d);
        add_beat(scpr_pkg::MODE_RECEIVE, d, rnd8(0, 255));
    endtask

    // framed command, optionally with one corrupted code byte
    task automatic add_command(logic [63:0] code, bit broken);
        int bad_pos;
        logic [7:0] d;
        bad_pos = broken ? $urandom_range(0, CODE_LEN - 1) : CODE_LEN;
        add_rx(scpr_pkg::CMD_OPEN);
        for (int i = 0; i < CODE_LEN; i++)
        begin
            d = code[8*i +: 8];
            if (i == bad_pos) d = d ^ rnd8(1, 255);
            add_rx(d);
        end
        add_rx(rnd8(0, 255));
        repeat ($urandom_range(0, 3)) add_rx(rnd8(0, 254));
        add_rx(scpr_pkg::CMD_CLOSE);
    endtask

    // random traffic shaped by the current receive phase
    task automatic fill_phase(int n);
        int base;
        int pick;
        logic [63:0] code;
        base = pending_beats.size();
        code = (cfg_phase == scpr_pkg::PHASE_RESET_DETECT) ? cfg_reset_code : cfg_start_code;
        while (pending_beats.size() - base < n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
            begin
                if (cfg_phase == scpr_pkg::PHASE_IMAGE_COUNT)
                begin
                    repeat ($urandom_range(0, 60)) add_rx(scpr_pkg::ZERO_BYTE);
                    add_rx(rnd8(1, 255));
                end
                else if (cfg_phase == scpr_pkg::PHASE_STORE_ONLY)
                begin
                    add_rx(rnd8(0, 255));
                end
                else
                begin
                    add_command(code, $urandom_range(0, 3) == 0);
                end
            end
            else if (pick < 75) add_rx(rnd8(0, 255));
            else if (pick < 90) add_beat(scpr_pkg::MODE_READ, rnd8(0, 255), rnd8(0, 255));
            else if (pick < 96) add_beat(scpr_pkg::MODE_CLEAR_FLAGS, rnd8(0, 255), rnd8(0, 255));
            else if (pick < 98) add_beat(scpr_pkg::MODE_CLEAR, rnd8(0, 255), rnd8(0, 255));
            else add_rx(scpr_pkg::CMD_OPEN);
        end
    endtask

    // wait until nothing is in flight, then let the pipeline settle
    task automatic wait_drained();
        @(negedge clk);
        while (pending_beats.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(logic [scpr_pkg::CFG_INDEX_W-1:0] idx, logic [63:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        unique case (idx)
            scpr_pkg::REG_RECEIVE_PHASE:      cfg_phase = value[1:0];
            scpr_pkg::REG_START_CODE:         cfg_start_code = value;
            scpr_pkg::REG_RESET_CODE:         cfg_reset_code = value;
            scpr_pkg::REG_ZERO_RUN_THRESHOLD: cfg_zero_threshold = value[7:0];
            scpr_pkg::REG_IMAGE_END_LIMIT:    cfg_image_limit = value[23:0];
            default: ;
        endcase
        cfg_writes++;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_config(logic [1:0] phase, logic [63:0] start_code,
                              logic [63:0] reset_code, logic [7:0] threshold,
                              logic [23:0] limit);
        write_reg(scpr_pkg::REG_RECEIVE_PHASE, {62'd0, phase});
        write_reg(scpr_pkg::REG_START_CODE, start_code);
        write_reg(scpr_pkg::REG_RESET_CODE, reset_code);
        write_reg(scpr_pkg::REG_ZERO_RUN_THRESHOLD, {56'd0, threshold});
        write_reg(scpr_pkg::REG_IMAGE_END_LIMIT, {40'd0, limit});
    endtask

    // main sequence
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: reads of an empty buffer, a clean start command, flag and buffer
        // clears, and a mismatching open byte that must not restart the matcher
        add_beat(scpr_pkg::MODE_READ, 8'h00, 8'h00);
        add_beat(scpr_pkg::MODE_READ, 8'hFF, 8'hFF);
        add_command(scpr_pkg::START_CODE_RESET, 1'b0);
        add_beat(scpr_pkg::MODE_READ, 8'h00, 8'd10);
        add_beat(scpr_pkg::MODE_CLEAR_FLAGS, 8'hFF, 8'h00);
        add_rx(scpr_pkg::CMD_OPEN);
        add_rx(scpr_pkg::CMD_OPEN);
        add_rx(8'h01);
        add_rx(8'hFF);
        add_beat(scpr_pkg::MODE_CLEAR, 8'h00, 8'hFF);
        add_beat(scpr_pkg::MODE_READ, 8'h00, 8'd3);
        add_beat(scpr_pkg::MODE_READ, 8'hFF, 8'd0);
        wait_drained();

        // start detect with random codes
        set_config(scpr_pkg::PHASE_START_DETECT, {$urandom, $urandom}, {$urandom, $urandom},
                   rnd8(0, 255), 24'($urandom_range(0, 300)));
        fill_phase(150);
        wait_drained();

        // reset detect with an all-ones code
        set_config(scpr_pkg::PHASE_RESET_DETECT, cfg_start_code, {64{1'b1}}, 8'd50, 24'd0);
        fill_phase(120);
        wait_drained();

        // image count at the lowest limits, sender held mid-phase until all results land
        set_config(scpr_pkg::PHASE_IMAGE_COUNT, cfg_start_code, cfg_reset_code, 8'd0, 24'd0);
        fill_phase(150);
        @(negedge clk);
        while (pending_beats.size() > 100) @(negedge clk);
        sender_hold = 1'b1;
        while (in_valid || expected_results.size() != 0) @(negedge clk);
        repeat (5) @(negedge clk);
        sender_hold = 1'b0;
        wait_drained();

        // image count at the highest limits, long zero run to saturate
        set_config(scpr_pkg::PHASE_IMAGE_COUNT, cfg_start_code, cfg_reset_code, 8'hFF,
                   24'hFF_FFFF);
        repeat (300) add_rx(scpr_pkg::ZERO_BYTE);
        fill_phase(40);
        wait_drained();

        // image count at mid limits, no idling on either side
        no_idle = 1'b1;
        set_config(scpr_pkg::PHASE_IMAGE_COUNT, cfg_start_code, cfg_reset_code,
                   rnd8(0, 60), 24'($urandom_range(0, 400)));
        fill_phase(150);
        wait_drained();
        no_idle = 1'b0;

        // start detect with an all-zero code
        set_config(scpr_pkg::PHASE_START_DETECT, 64'd0, cfg_reset_code, 8'd10, 24'd5);
        fill_phase(100);
        wait_drained();

        // store only
        write_reg(scpr_pkg::REG_RECEIVE_PHASE, {62'd0, scpr_pkg::PHASE_STORE_ONLY});
        fill_phase(80);
        wait_drained();

        // reset detect with a random code
        set_config(scpr_pkg::PHASE_RESET_DETECT, cfg_start_code, {$urandom, $urandom},
                   rnd8(0, 255), 24'($urandom_range(0, 16777215)));
        fill_phase(100);
        wait_drained();

        // short burst with no idling, then reads around a buffer clear
        no_idle = 1'b1;
        set_config(scpr_pkg::PHASE_IMAGE_COUNT, cfg_start_code, cfg_reset_code, 8'd20, 24'd30);
        repeat (60) add_rx(($urandom_range(0, 9) == 0) ? rnd8(1, 255) : scpr_pkg::ZERO_BYTE);
        repeat (4) add_beat(scpr_pkg::MODE_READ, rnd8(0, 255), rnd8(0, 255));
        add_beat(scpr_pkg::MODE_CLEAR, rnd8(0, 255), rnd8(0, 255));
        add_beat(scpr_pkg::MODE_READ, rnd8(0, 255), rnd8(0, 255));
        wait_drained();
        no_idle = 1'b0;

        repeat (20) @(negedge clk);
        mismatches += expected_results.size();
        $display("run covered %0d beats, %0d results checked, %0d register writes",
                 beats_sent, results_checked, cfg_writes);
        $display("commands completed %0d, end-of-image results %0d, failures %0d",
                 commands_found, end_flags, mismatches);
        if (mismatches == 0)
        begin
            $display("serial_command_pattern_receiver_test: PASS");
        end
        else
        begin
            $display("serial_command_pattern_receiver_test: FAIL");
        end
        $finish;
    end

    // watchdog
    initial
    begin
        #30ms;
        $display("timeout waiting for results");
        $display("serial_command_pattern_receiver_test: FAIL");
        $finish;
    end

endmodule
